[rtl/core/http_request_byte_classifier_macros.svh]
// ----------------------------------------------------------------------------
// HTTP request byte classifier assertion macros
// Concurrent assertion wrappers shared by the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_BYTE_CLASSIFIER_MACROS_SVH
`define HTTP_REQUEST_BYTE_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property that is switched off while reset is held.
`define HRBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds through reset.
`define HRBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HRBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define HRBC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/hrbc_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP request byte classifier package
// Codes, character constants and helper functions for the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package hrbc_pkg;

    typedef logic [3:0] t_phase;
    typedef logic [3:0] t_match;
    typedef logic [3:0] t_role;
    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_term;

    localparam t_phase PH_METHOD   = 4'd0;
    localparam t_phase PH_SP1      = 4'd1;
    localparam t_phase PH_ENDPOINT = 4'd2;
    localparam t_phase PH_SP2      = 4'd3;
    localparam t_phase PH_PROTO    = 4'd4;
    localparam t_phase PH_SP3      = 4'd5;
    localparam t_phase PH_EXTRA    = 4'd6;
    localparam t_phase PH_HEADER   = 4'd7;
    localparam t_phase PH_BODY     = 4'd8;

    localparam t_match MM_NONE  = 4'd0;
    localparam t_match MM_G     = 4'd1;
    localparam t_match MM_GE    = 4'd2;
    localparam t_match MM_GET   = 4'd3;
    localparam t_match MM_P     = 4'd4;
    localparam t_match MM_PO    = 4'd5;
    localparam t_match MM_POS   = 4'd6;
    localparam t_match MM_POST  = 4'd7;
    localparam t_match MM_PA    = 4'd8;
    localparam t_match MM_PAT   = 4'd9;
    localparam t_match MM_PATC  = 4'd10;
    localparam t_match MM_PATCH = 4'd11;
    localparam t_match MM_FAIL  = 4'd15;

    localparam t_term TS_IDLE  = 2'd0;
    localparam t_term TS_LF    = 2'd1;
    localparam t_term TS_LF_CR = 2'd2;
    localparam t_term TS_CR    = 2'd3;

    localparam t_role ROLE_METHOD  = 4'd0;
    localparam t_role ROLE_SPACE   = 4'd1;
    localparam t_role ROLE_ENDPT   = 4'd2;
    localparam t_role ROLE_PROTO   = 4'd3;
    localparam t_role ROLE_EXTRA   = 4'd4;
    localparam t_role ROLE_TERM    = 4'd5;
    localparam t_role ROLE_KEY     = 4'd6;
    localparam t_role ROLE_COLON   = 4'd7;
    localparam t_role ROLE_SKIP    = 4'd8;
    localparam t_role ROLE_VALUE   = 4'd9;
    localparam t_role ROLE_BODY    = 4'd10;

    localparam t_kind KIND_GET   = 2'd0;
    localparam t_kind KIND_POST  = 2'd1;
    localparam t_kind KIND_PATCH = 2'd2;
    localparam t_kind KIND_ERROR = 2'd3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic t_match method_next(input t_match m, input logic [7:0] c);
        t_match r;
        r = MM_FAIL;
        case (m)
            MM_NONE: begin
                if (c == "G") r = MM_G;
                else if (c == "P") r = MM_P;
            end
            MM_G:    if (c == "E") r = MM_GE;
            MM_GE:   if (c == "T") r = MM_GET;
            MM_P: begin
                if (c == "O") r = MM_PO;
                else if (c == "A") r = MM_PA;
            end
            MM_PO:   if (c == "S") r = MM_POS;
            MM_POS:  if (c == "T") r = MM_POST;
            MM_PA:   if (c == "T") r = MM_PAT;
            MM_PAT:  if (c == "C") r = MM_PATC;
            MM_PATC: if (c == "H") r = MM_PATCH;
            default: r = MM_FAIL;
        endcase
        return r;
    endfunction

    function automatic logic method_ok(input t_match m);
        return (m == MM_GET) || (m == MM_POST) || (m == MM_PATCH);
    endfunction

    // True when the line that is still open would make the request invalid.
    function automatic logic line_error(input t_phase ph, input t_match m,
                                        input logic empty, input logic colon);
        logic e;
        e = 1'b0;
        if (ph <= PH_EXTRA) begin
            e = (ph <= PH_SP2) || !method_ok(m);
        end else if (ph == PH_HEADER) begin
            e = !empty && !colon;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

[rtl/core/http_request_byte_classifier.sv]
// ----------------------------------------------------------------------------
// HTTP request byte classifier
// Tags each byte of an HTTP request with its role and reports the request
// kind on the final byte.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_ready    i_data_byte, i_last
//   result   out        o_valid / i_ready    o_data_out, o_byte_role,
//                                            o_request_kind, o_end_of_request
//
// One byte is taken per cycle unless the result side stalls.
// The parser state is updated as a byte moves from the input register to the
// result register, so consecutive bytes follow each other without gaps.
// A stalled result register holds the input register, which then stalls input.
// Synchronous reset clears both registers' valid flags and the parser state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_request_byte_classifier_macros.svh"

module http_request_byte_classifier (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_data_out,
    output logic [3:0]      o_byte_role,
    output logic [1:0]      o_request_kind,
    output logic            o_end_of_request
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;

    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    hrbc_pkg::t_role     r_out_role;
    hrbc_pkg::t_kind     r_out_kind;
    logic                r_out_last;

    hrbc_pkg::t_phase    r_phase, n_phase;
    hrbc_pkg::t_match    r_match, n_match;
    hrbc_pkg::t_term     r_term, n_term;
    logic                r_empty, n_empty;
    logic                r_error, n_error;
    logic                r_colon, n_colon;
    logic                r_vstart, n_vstart;
    hrbc_pkg::t_role     n_role;
    hrbc_pkg::t_kind     n_kind;

    logic                w_advance;
    logic                w_move;

    assign w_advance = !r_out_valid || i_ready;
    assign w_move    = r_in_valid && w_advance;
    assign o_ready   = !r_in_valid || w_advance;

    always_comb begin
        logic [7:0] c;
        logic       ws;
        c        = r_in_byte;
        ws       = hrbc_pkg::is_ws(c);
        n_phase  = r_phase;
        n_match  = r_match;
        n_term   = r_term;
        n_empty  = r_empty;
        n_error  = r_error;
        n_colon  = r_colon;
        n_vstart = r_vstart;
        n_kind   = hrbc_pkg::KIND_GET;
        n_role   = hrbc_pkg::ROLE_BODY;

        if (r_term == hrbc_pkg::TS_LF && c == hrbc_pkg::CH_CR) begin
            n_term = hrbc_pkg::TS_LF_CR;
            n_role = hrbc_pkg::ROLE_TERM;
        end else if ((r_term == hrbc_pkg::TS_LF_CR || r_term == hrbc_pkg::TS_CR)
                     && c == hrbc_pkg::CH_LF) begin
            n_term = hrbc_pkg::TS_IDLE;
            n_role = hrbc_pkg::ROLE_TERM;
        end else begin
            n_term = hrbc_pkg::TS_IDLE;
            if (r_phase == hrbc_pkg::PH_BODY) begin
                n_role = hrbc_pkg::ROLE_BODY;
            end else if (c == hrbc_pkg::CH_LF || c == hrbc_pkg::CH_CR) begin
                n_term = (c == hrbc_pkg::CH_LF) ? hrbc_pkg::TS_LF : hrbc_pkg::TS_CR;
                if (hrbc_pkg::line_error(r_phase, r_match, r_empty, r_colon)) begin
                    n_error = 1'b1;
                end
                n_phase  = (r_phase == hrbc_pkg::PH_HEADER && r_empty) ?
                           hrbc_pkg::PH_BODY : hrbc_pkg::PH_HEADER;
                n_empty  = 1'b1;
                n_colon  = 1'b0;
                n_vstart = 1'b0;
                n_role   = hrbc_pkg::ROLE_TERM;
            end else begin
                n_empty = 1'b0;
                case (r_phase)
                    hrbc_pkg::PH_METHOD: begin
                        if (ws) begin
                            n_phase = hrbc_pkg::PH_SP1;
                            n_role  = hrbc_pkg::ROLE_SPACE;
                        end else begin
                            n_match = hrbc_pkg::method_next(r_match, c);
                            n_role  = hrbc_pkg::ROLE_METHOD;
                        end
                    end
                    hrbc_pkg::PH_SP1: begin
                        if (ws) begin
                            n_role = hrbc_pkg::ROLE_SPACE;
                        end else begin
                            n_phase = hrbc_pkg::PH_ENDPOINT;
                            n_role  = hrbc_pkg::ROLE_ENDPT;
                        end
                    end
                    hrbc_pkg::PH_ENDPOINT: begin
                        if (ws) begin
                            n_phase = hrbc_pkg::PH_SP2;
                            n_role  = hrbc_pkg::ROLE_SPACE;
                        end else begin
                            n_role = hrbc_pkg::ROLE_ENDPT;
                        end
                    end
                    hrbc_pkg::PH_SP2: begin
                        if (ws) begin
                            n_role = hrbc_pkg::ROLE_SPACE;
                        end else begin
                            n_phase = hrbc_pkg::PH_PROTO;
                            n_role  = hrbc_pkg::ROLE_PROTO;
                        end
                    end
                    hrbc_pkg::PH_PROTO: begin
                        if (ws) begin
                            n_phase = hrbc_pkg::PH_SP3;
                            n_role  = hrbc_pkg::ROLE_SPACE;
                        end else begin
                            n_role = hrbc_pkg::ROLE_PROTO;
                        end
                    end
                    hrbc_pkg::PH_SP3: begin
                        if (ws) begin
                            n_role = hrbc_pkg::ROLE_SPACE;
                        end else begin
                            n_phase = hrbc_pkg::PH_EXTRA;
                            n_error = 1'b1;
                            n_role  = hrbc_pkg::ROLE_EXTRA;
                        end
                    end
                    hrbc_pkg::PH_EXTRA: begin
                        n_role = hrbc_pkg::ROLE_EXTRA;
                    end
                    hrbc_pkg::PH_HEADER: begin
                        if (!r_colon) begin
                            if (c == hrbc_pkg::CH_COLON) begin
                                n_colon = 1'b1;
                                n_role  = hrbc_pkg::ROLE_COLON;
                            end else begin
                                n_role = hrbc_pkg::ROLE_KEY;
                            end
                        end else if (!r_vstart && ws) begin
                            n_role = hrbc_pkg::ROLE_SKIP;
                        end else begin
                            n_vstart = 1'b1;
                            n_role   = hrbc_pkg::ROLE_VALUE;
                        end
                    end
                    default: begin
                        n_role = hrbc_pkg::ROLE_BODY;
                    end
                endcase
            end
        end

        if (r_in_last) begin
            if (n_error || hrbc_pkg::line_error(n_phase, n_match, n_empty, n_colon)) begin
                n_kind = hrbc_pkg::KIND_ERROR;
            end else if (n_match == hrbc_pkg::MM_GET) begin
                n_kind = hrbc_pkg::KIND_GET;
            end else if (n_match == hrbc_pkg::MM_POST) begin
                n_kind = hrbc_pkg::KIND_POST;
            end else if (n_match == hrbc_pkg::MM_PATCH) begin
                n_kind = hrbc_pkg::KIND_PATCH;
            end else begin
                n_kind = hrbc_pkg::KIND_ERROR;
            end
            n_phase  = hrbc_pkg::PH_METHOD;
            n_match  = hrbc_pkg::MM_NONE;
            n_term   = hrbc_pkg::TS_IDLE;
            n_empty  = 1'b1;
            n_error  = 1'b0;
            n_colon  = 1'b0;
            n_vstart = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= hrbc_pkg::PH_METHOD;
            r_match     <= hrbc_pkg::MM_NONE;
            r_term      <= hrbc_pkg::TS_IDLE;
            r_empty     <= 1'b1;
            r_error     <= 1'b0;
            r_colon     <= 1'b0;
            r_vstart    <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_move) begin
                r_phase  <= n_phase;
                r_match  <= n_match;
                r_term   <= n_term;
                r_empty  <= n_empty;
                r_error  <= n_error;
                r_colon  <= n_colon;
                r_vstart <= n_vstart;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
        if (w_move) begin
            r_out_byte <= r_in_byte;
            r_out_role <= n_role;
            r_out_kind <= n_kind;
            r_out_last <= r_in_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_data_out       = r_out_byte;
    assign o_byte_role      = r_out_role;
    assign o_request_kind   = r_out_kind;
    assign o_end_of_request = r_out_last;

    `HRBC_ASSERT(a_kind_only_at_end, i_clk, i_rst_n, (o_valid && !o_end_of_request) |-> (o_request_kind == hrbc_pkg::KIND_GET), "request kind set on a byte that is not the last")
    `HRBC_ASSERT(a_state_cleared_after_last, i_clk, i_rst_n, (w_move && r_in_last) |=> (r_phase == hrbc_pkg::PH_METHOD && r_match == hrbc_pkg::MM_NONE && !r_error), "parser state not cleared after the last byte")
    `HRBC_ASSERT(a_term_only_after_first_line, i_clk, i_rst_n, (r_term != hrbc_pkg::TS_IDLE) |-> (r_phase == hrbc_pkg::PH_HEADER || r_phase == hrbc_pkg::PH_BODY), "terminator tracking active on the first line")

endmodule

`default_nettype wire

[tb/byte_role_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte role checker
// Watches both channels of the HTTP request byte classifier. Every byte taken
// on the input is run through a model of the parser to work out its role,
// and the request kind on a closing byte. The outcome waits in order until
// the matching result transfer, which is then compared field by field.
// ----------------------------------------------------------------------------
module byte_role_checker
    import hrbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [7:0] i_res_data,
    input  logic [3:0] i_res_role,
    input  logic [1:0] i_res_kind,
    input  logic       i_res_end,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    typedef struct packed {
        logic [7:0] data;
        t_role      role;
        t_kind      kind;
        logic       eor;
    } t_role_rec;

    t_role_rec   expected_roles[$];
    int          fails;
    int          checked;

    t_phase      phase;
    logic [39:0] meth_text;
    int          meth_len;
    t_term       term;
    logic        line_empty;
    logic        err_seen;
    logic        colon_seen;
    logic        value_seen;

    function automatic t_kind method_kind();
        if (meth_len == 3 && meth_text[23:0] == "GET") return KIND_GET;
        if (meth_len == 4 && meth_text[31:0] == "POST") return KIND_POST;
        if (meth_len == 5 && meth_text == "PATCH") return KIND_PATCH;
        return KIND_ERROR;
    endfunction

    task automatic clear_parser();
        phase      = PH_METHOD;
        meth_text  = '0;
        meth_len   = 0;
        term       = TS_IDLE;
        line_empty = 1'b1;
        err_seen   = 1'b0;
        colon_seen = 1'b0;
        value_seen = 1'b0;
    endtask

    task automatic judge_line();
        if (phase <= PH_EXTRA) begin
            if (phase <= PH_SP2 || method_kind() == KIND_ERROR) err_seen = 1'b1;
        end else if (phase == PH_HEADER && !line_empty && !colon_seen) begin
            err_seen = 1'b1;
        end
    endtask

    task automatic classify_byte(input logic [7:0] c, input logic closing,
                                 output t_role role, output t_kind kind);
        logic ws;
        ws   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
        kind = KIND_GET;
        if (term == TS_LF && c == CH_CR) begin
            term = TS_LF_CR;
            role = ROLE_TERM;
        end else if ((term == TS_LF_CR || term == TS_CR) && c == CH_LF) begin
            term = TS_IDLE;
            role = ROLE_TERM;
        end else begin
            term = TS_IDLE;
            if (phase == PH_BODY) begin
                role = ROLE_BODY;
            end else if (c == CH_LF || c == CH_CR) begin
                term = (c == CH_LF) ? TS_LF : TS_CR;
                judge_line();
                phase      = (phase == PH_HEADER && line_empty) ? PH_BODY : PH_HEADER;
                line_empty = 1'b1;
                colon_seen = 1'b0;
                value_seen = 1'b0;
                role       = ROLE_TERM;
            end else begin
                line_empty = 1'b0;
                case (phase)
                    PH_METHOD: begin
                        if (ws) begin
                            phase = PH_SP1;
                            role  = ROLE_SPACE;
                        end else begin
                            meth_text = {meth_text[31:0], c};
                            if (meth_len < 6) meth_len++;
                            role = ROLE_METHOD;
                        end
                    end
                    PH_SP1: begin
                        if (ws) begin
                            role = ROLE_SPACE;
                        end else begin
                            phase = PH_ENDPOINT;
                            role  = ROLE_ENDPT;
                        end
                    end
                    PH_ENDPOINT: begin
                        if (ws) begin
                            phase = PH_SP2;
                            role  = ROLE_SPACE;
                        end else begin
                            role = ROLE_ENDPT;
                        end
                    end
                    PH_SP2: begin
                        if (ws) begin
                            role = ROLE_SPACE;
                        end else begin
                            phase = PH_PROTO;
                            role  = ROLE_PROTO;
                        end
                    end
                    PH_PROTO: begin
                        if (ws) begin
                            phase = PH_SP3;
                            role  = ROLE_SPACE;
                        end else begin
                            role = ROLE_PROTO;
                        end
                    end
                    PH_SP3: begin
                        if (ws) begin
                            role = ROLE_SPACE;
                        end else begin
                            phase    = PH_EXTRA;
                            err_seen = 1'b1;
                            role     = ROLE_EXTRA;
                        end
                    end
                    PH_EXTRA: begin
                        role = ROLE_EXTRA;
                    end
                    default: begin
                        if (!colon_seen) begin
                            if (c == CH_COLON) begin
                                colon_seen = 1'b1;
                                role       = ROLE_COLON;
                            end else begin
                                role = ROLE_KEY;
                            end
                        end else if (!value_seen && ws) begin
                            role = ROLE_SKIP;
                        end else begin
                            value_seen = 1'b1;
                            role       = ROLE_VALUE;
                        end
                    end
                endcase
            end
        end
        if (closing) begin
            judge_line();
            kind = err_seen ? KIND_ERROR : method_kind();
            clear_parser();
        end
    endtask

    always @(posedge i_clk) begin
        t_role_rec want;
        t_role     role;
        t_kind     kind;
        if (!i_rst_n) begin
            clear_parser();
            expected_roles.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                classify_byte(i_in_byte, i_in_last, role, kind);
                expected_roles.push_back('{i_in_byte, role, kind, i_in_last});
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_roles.size() == 0) begin
                    $error("Result transfer with no byte outstanding: data_out %02h",
                           i_res_data);
                    fails++;
                end else begin
                    want = expected_roles.pop_front();
                    checked++;
                    if (i_res_data !== want.data) begin
                        $error("data_out: expected %02h, got %02h", want.data, i_res_data);
                        fails++;
                    end
                    if (i_res_role !== want.role) begin
                        $error("byte_role: expected %0d, got %0d", want.role, i_res_role);
                        fails++;
                    end
                    if (i_res_kind !== want.kind) begin
                        $error("request_kind: expected %0d, got %0d", want.kind, i_res_kind);
                        fails++;
                    end
                    if (i_res_end !== want.eor) begin
                        $error("end_of_request: expected %0d, got %0d", want.eor, i_res_end);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_roles.size();
        o_checked    <= checked;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP request byte classifier testbench
// Feeds a handful of hand-written requests, then random requests: some
// well-formed, with random tokens, headers and bodies, the rest with bad
// methods, missing protocols, stray tokens, headers without a colon, noise
// or a cut-short end. Both channels idle at random; the result side is held
// off for long stretches and the input is drained now and then. A checker
// module beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import hrbc_pkg::*;

    localparam int BC_TOKEN   = 0;
    localparam int BC_KEY     = 1;
    localparam int BC_TEXT    = 2;
    localparam int BC_ANY     = 3;
    localparam int BC_WS      = 4;
    localparam int RAND_BYTES = 1150;
    localparam int HOLD_CYC   = 200;
    localparam int IDLE_LIMIT = 3000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       i_last;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_data_out;
    logic [3:0] o_byte_role;
    logic [1:0] o_request_kind;
    logic       o_end_of_request;

    int         fail_count;
    int         pending;
    int         checked;

    logic [7:0] req_bytes[$];
    bit         tx_fast;
    bit         rx_fast;
    bit         rx_hold;
    int         bytes_sent;
    int         n_requests;
    int         n_bad;
    int         n_holds;
    int         n_drains;
    int         idle_cycles;

    http_request_byte_classifier u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_data_out       (o_data_out),
        .o_byte_role      (o_byte_role),
        .o_request_kind   (o_request_kind),
        .o_end_of_request (o_end_of_request)
    );

    byte_role_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_byte    (i_data_byte),
        .i_in_last    (i_last),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_res_data   (o_data_out),
        .i_res_role   (o_byte_role),
        .i_res_kind   (o_request_kind),
        .i_res_end    (o_end_of_request),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] rand_byte(input int cls);
        logic [7:0] b;
        if (cls == BC_WS) begin
            case ($urandom_range(0, 3))
                0:       return CH_SPACE;
                1:       return CH_TAB;
                2:       return CH_VT;
                default: return CH_FF;
            endcase
        end
        do begin
            b = 8'($urandom_range(0, 255));
        end while (cls != BC_ANY && (b == CH_LF || b == CH_CR
                   || (cls == BC_TOKEN && (b == CH_SPACE || b == CH_TAB
                                           || b == CH_VT || b == CH_FF))
                   || (cls == BC_KEY && b == CH_COLON)));
        return b;
    endfunction

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) req_bytes.push_back(s[k]);
    endtask

    task automatic push_run(input int n, input int cls);
        repeat (n) req_bytes.push_back(rand_byte(cls));
    endtask

    task automatic push_eol();
        case ($urandom_range(0, 4))
            0:       push_text("\n");
            1:       push_text("\015");
            2:       push_text("\015\n");
            3:       push_text("\n\015");
            default: push_text("\n\015\n");
        endcase
    endtask

    task automatic send_request();
        int gap;
        for (int k = 0; k < req_bytes.size(); k++) begin
            gap = tx_fast ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_data_byte <= req_bytes[k];
            i_last      <= (k == req_bytes.size() - 1);
            do @(posedge i_clk); while (!o_ready);
        end
        bytes_sent += req_bytes.size();
        n_requests++;
        req_bytes.delete();
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        n_drains++;
    endtask

    initial begin
        int rand_start;
        int nh;
        bit bad;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_last      = 1'b0;
        tx_fast     = 1'b0;
        rx_hold     = 1'b0;
        bytes_sent  = 0;
        n_requests  = 0;
        n_bad       = 0;
        n_holds     = 0;
        n_drains    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_text("GET a b\015k:\t v\n\n");
        req_bytes.push_back(8'hFF);
        push_text("\015");
        req_bytes.push_back(8'h00);
        send_request();
        push_text(" a b c\n\015\n");
        send_request();
        push_text("PATCH a b");
        send_request();
        push_text("POST x y\015\n\015\n");
        send_request();
        push_text("GET a\n");
        send_request();
        push_text("GET a b c");
        send_request();
        push_text("GET a b\nk\n");
        send_request();
        push_text("GETS a");
        req_bytes.push_back(CH_VT);
        push_text("b");
        send_request();
        n_bad += 5;
        wait_drained();

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_BYTES) begin
            bad     = 1'b0;
            tx_fast = ($urandom_range(0, 3) == 0);
            if (n_requests == 12 || $urandom_range(0, 59) == 0) begin
                rx_hold = 1'b1;
                n_holds++;
            end
            if ($urandom_range(0, 9) == 0) begin
                push_run($urandom_range(1, 20), BC_ANY);
                bad = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: push_text("GET");
                    3, 4:    push_text("POST");
                    5, 6:    push_text("PATCH");
                    7: begin
                        push_run($urandom_range(1, 2), BC_WS);
                        bad = 1'b1;
                    end
                    8: begin
                        case ($urandom_range(0, 4))
                            0:       push_text("GE");
                            1:       push_text("GETT");
                            2:       push_text("PUT");
                            3:       push_text("POSTS");
                            default: push_text("PATC");
                        endcase
                        bad = 1'b1;
                    end
                    default: begin
                        push_run($urandom_range(1, 6), BC_TOKEN);
                        bad = 1'b1;
                    end
                endcase
                push_run($urandom_range(1, 3), BC_WS);
                push_run($urandom_range(1, 8), BC_TOKEN);
                if ($urandom_range(0, 9) == 0) begin
                    bad = 1'b1;
                end else begin
                    push_run($urandom_range(1, 3), BC_WS);
                    if ($urandom_range(0, 1) == 0) push_text("HTTP/1.1");
                    else push_run($urandom_range(1, 8), BC_TOKEN);
                    if ($urandom_range(0, 9) == 0) begin
                        push_run($urandom_range(1, 2), BC_WS);
                        push_run($urandom_range(1, 4), BC_TOKEN);
                        bad = 1'b1;
                    end
                end
                if ($urandom_range(0, 19) == 0) push_run(1, BC_WS);
                push_eol();
                nh = $urandom_range(0, 3);
                repeat (nh) begin
                    if ($urandom_range(0, 9) == 0) begin
                        push_run($urandom_range(1, 8), BC_KEY);
                        bad = 1'b1;
                    end else begin
                        push_run($urandom_range(0, 6), BC_KEY);
                        push_text(":");
                        push_run($urandom_range(0, 2), BC_WS);
                        push_run($urandom_range(0, 8), BC_TEXT);
                    end
                    push_eol();
                end
                push_eol();
                push_run($urandom_range(0, 12), BC_ANY);
            end
            if ($urandom_range(0, 6) == 0) begin
                req_bytes = req_bytes[0:$urandom_range(0, req_bytes.size() - 1)];
                bad = 1'b1;
            end
            if (bad) n_bad++;
            send_request();
            if (n_requests == 30 || $urandom_range(0, 39) == 0) wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Classified %0d bytes in %0d requests, %0d malformed, noisy or cut short;",
                 bytes_sent, n_requests, n_bad);
        $display("%0d results compared, %0d long result stalls, %0d input drains.",
                 checked, n_holds, n_drains);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        int gap;
        int rx_count;
        i_ready  = 1'b0;
        rx_fast  = 1'b0;
        rx_count = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold) begin
                rx_hold = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
            end
            if (rx_count % 40 == 0) rx_fast = ($urandom_range(0, 2) == 0);
            gap = rx_fast ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            rx_count++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
